// ===== rtl/core/ljpf_pkg.sv =====
// Shared widths, register indexes, stage interface types and output clipping.
`timescale 1ns / 1ps

package ljpf_pkg;

    localparam int FRAC_BITS = 24;
    localparam int POS_W     = 32;
    localparam int CFG_W     = 32;
    localparam int TAG_W     = 16;
    localparam int OUT_W     = 48;
    localparam int MAG_W     = 62;
    localparam int SQ_W      = 2 * POS_W + 2;
    localparam int R2_W      = SQ_W - FRAC_BITS;
    localparam int QUO_W     = CFG_W + FRAC_BITS;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int MUL_LAT   = 3;

    // sticky overflow magnitude, all ones
    localparam logic [MAG_W-1:0] BIG_MAG = '1;

    localparam logic signed [63:0] MAX_OUT = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] MIN_OUT = -MAX_OUT - 64'sd1;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx REG_BOX_X        = 3'd0;
    localparam t_cfg_idx REG_BOX_Y        = 3'd1;
    localparam t_cfg_idx REG_BOX_Z        = 3'd2;
    localparam t_cfg_idx REG_SIGMA_SQ     = 3'd3;
    localparam t_cfg_idx REG_WELL_DEPTH   = 3'd4;
    localparam t_cfg_idx REG_CUTOFF_SQ    = 3'd5;
    localparam t_cfg_idx REG_ENERGY_SHIFT = 3'd6;

    // distance front end result
    typedef struct packed {
        logic [R2_W-1:0]        r2;
        logic [2:0][POS_W-1:0]  dmag;
        logic [2:0]             dneg;
        logic [TAG_W-1:0]       tag;
    } t_dist;

    // sideband that rides along the divider and multiplier chain
    typedef struct packed {
        logic [2:0][POS_W-1:0]  dmag;
        logic [2:0]             dneg;
        logic [TAG_W-1:0]       tag;
        logic                   in_range;
        logic                   zero;
    } t_side;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             sat;
    } t_clip;

    // clip a signed value to the output range
    function automatic t_clip clip_out(input logic signed [63:0] v);
        t_clip c;
        logic signed [63:0] t;
        c.sat = 1'b0;
        t = v;
        if (v > MAX_OUT) begin
            t = MAX_OUT;
            c.sat = 1'b1;
        end
        if (v < MIN_OUT) begin
            t = MIN_OUT;
            c.sat = 1'b1;
        end
        c.val = t[OUT_W-1:0];
        return c;
    endfunction

endpackage

// ===== rtl/core/ljpf_dist.sv =====
// Minimum-image wrap and squared distance, five register stages.
`timescale 1ns / 1ps

module ljpf_dist import ljpf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2:0][POS_W-1:0]  i_pos_a,
    input  logic [2:0][POS_W-1:0]  i_pos_b,
    input  logic [2:0][CFG_W-1:0]  i_box,
    input  logic [TAG_W-1:0]       i_tag,
    output logic                   o_valid,
    output t_dist                  o_dist
);

    logic [4:0]                 r_vld;
    logic [4:0][TAG_W-1:0]      r_tag;
    logic signed [2:0][POS_W:0] r_d0;
    logic signed [2:0][POS_W:0] r_d;
    logic [2:0][POS_W-1:0]      r_mag3, r_mag4, r_mag5;
    logic [2:0]                 r_neg3, r_neg4, r_neg5;
    logic [2:0][2*POS_W-1:0]    r_sq;
    logic [R2_W-1:0]            r_r2;

    logic signed [2:0][POS_W:0] n_d;
    logic [2:0][POS_W-1:0]      n_mag;
    logic [SQ_W-1:0]            n_sum;

    // wrap by one box length at most, then magnitude and sum of squares
    always_comb begin
        logic signed [POS_W+2:0] x, l, w;
        logic signed [POS_W:0]   m;
        for (int k = 0; k < 3; k++) begin
            x = {{2{r_d0[k][POS_W]}}, r_d0[k]};
            l = {3'b000, i_box[k]};
            if ((x <<< 1) > l) begin
                w = x - l;
            end else if ((x <<< 1) < -l) begin
                w = x + l;
            end else begin
                w = x;
            end
            n_d[k] = w[POS_W:0];
            m = r_d[k][POS_W] ? -r_d[k] : r_d[k];
            n_mag[k] = m[POS_W-1:0];
        end
        n_sum = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= {r_tag[3:0], i_tag};
            for (int k = 0; k < 3; k++) begin
                r_d0[k]   <= $signed({1'b0, i_pos_a[k]}) - $signed({1'b0, i_pos_b[k]});
                r_d[k]    <= n_d[k];
                r_mag3[k] <= n_mag[k];
                r_neg3[k] <= r_d[k][POS_W];
                r_sq[k]   <= r_mag3[k] * r_mag3[k];
            end
            r_mag4 <= r_mag3;
            r_neg4 <= r_neg3;
            r_mag5 <= r_mag4;
            r_neg5 <= r_neg4;
            r_r2   <= n_sum[SQ_W-1:FRAC_BITS];
        end
    end

    assign o_valid     = r_vld[4];
    assign o_dist.r2   = r_r2;
    assign o_dist.dmag = r_mag5;
    assign o_dist.dneg = r_neg5;
    assign o_dist.tag  = r_tag[4];

endmodule

// ===== rtl/core/ljpf_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
`timescale 1ns / 1ps

module ljpf_div import ljpf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [R2_W-1:0]        i_den,
    input  logic [1:0][CFG_W-1:0]  i_num,
    output logic [1:0][QUO_W-1:0]  o_quo
);

    logic [QUO_W-1:0][1:0][R2_W-1:0]  r_rem;
    logic [QUO_W-1:0][1:0][QUO_W-1:0] r_nq;
    logic [QUO_W-1:0][R2_W-1:0]       r_den;

    logic [QUO_W-1:0][1:0][R2_W-1:0]  n_rem;
    logic [QUO_W-1:0][1:0][QUO_W-1:0] n_nq;

    // one shift-compare-subtract step per stage
    always_comb begin
        logic [R2_W-1:0]  rem, den;
        logic [QUO_W-1:0] nq;
        logic [R2_W:0]    sh, diff;
        logic             ge;
        for (int s = 0; s < QUO_W; s++) begin
            for (int j = 0; j < 2; j++) begin
                if (s == 0) begin
                    rem = '0;
                    nq  = {i_num[j], {FRAC_BITS{1'b0}}};
                    den = i_den;
                end else begin
                    rem = r_rem[s-1][j];
                    nq  = r_nq[s-1][j];
                    den = r_den[s-1];
                end
                sh   = {rem, nq[QUO_W-1]};
                diff = sh - {1'b0, den};
                ge   = (sh >= {1'b0, den});
                n_rem[s][j] = ge ? diff[R2_W-1:0] : sh[R2_W-1:0];
                n_nq[s][j]  = {nq[QUO_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_den[0] <= i_den;
            for (int s = 1; s < QUO_W; s++) begin
                r_den[s] <= r_den[s-1];
            end
        end
    end

    assign o_quo = r_nq[QUO_W-1];

endmodule

// ===== rtl/core/ljpf_mulq.sv =====
// Fixed-point product with sticky overflow, three stages of split partial products.
`timescale 1ns / 1ps

module ljpf_mulq import ljpf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MAG_W-1:0]  i_a,
    input  logic [MAG_W-1:0]  i_b,
    output logic [MAG_W-1:0]  o_p
);

    localparam int HALF = MAG_W / 2;

    logic [2*HALF-1:0] r_p00, r_p01, r_p10, r_p11;
    logic              r_zero1, r_big1, r_zero2, r_big2;
    logic [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]  r_res;

    logic [2*HALF:0]   w_mid;
    logic [PROD_W-1:0] w_prod;
    logic              w_over;

    // sum partial products, then check the part above the result and an all-ones result
    always_comb begin
        w_mid  = {1'b0, r_p01} + {1'b0, r_p10};
        w_prod = {r_p11, {(2*HALF){1'b0}}}
               + {{(PROD_W-3*HALF-1){1'b0}}, w_mid, {HALF{1'b0}}}
               + {{(PROD_W-2*HALF){1'b0}}, r_p00};
        w_over = (|r_prod[PROD_W-1:FRAC_BITS+MAG_W])
               | (&r_prod[FRAC_BITS+MAG_W-1:FRAC_BITS]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00   <= i_a[HALF-1:0]     * i_b[HALF-1:0];
            r_p01   <= i_a[HALF-1:0]     * i_b[MAG_W-1:HALF];
            r_p10   <= i_a[MAG_W-1:HALF] * i_b[HALF-1:0];
            r_p11   <= i_a[MAG_W-1:HALF] * i_b[MAG_W-1:HALF];
            r_zero1 <= (i_a == '0) || (i_b == '0);
            r_big1  <= (i_a == BIG_MAG) || (i_b == BIG_MAG);
            r_prod  <= w_prod;
            r_zero2 <= r_zero1;
            r_big2  <= r_big1;
            if (r_zero2) begin
                r_res <= '0;
            end else if (r_big2 || w_over) begin
                r_res <= BIG_MAG;
            end else begin
                r_res <= r_prod[FRAC_BITS+MAG_W-1:FRAC_BITS];
            end
        end
    end

    assign o_p = r_res;

endmodule

// ===== rtl/core/lennard_jones_pair_force_unit.sv =====
// Shifted Lennard-Jones pair force with minimum-image wrap, fixed-point pipeline.
// Throughput: one pair per cycle; depth is set by the 56 one-bit divider stages.
// Stalls hold the whole pipe; an input is still taken while a result waits if the last
// stage before the output register is empty.
// Reset: synchronous active low, clears valid bits and loads register defaults.
`timescale 1ns / 1ps

module lennard_jones_pair_force_unit import ljpf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [POS_W-1:0]        i_pos_a_x,
    input  logic [POS_W-1:0]        i_pos_a_y,
    input  logic [POS_W-1:0]        i_pos_a_z,
    input  logic [POS_W-1:0]        i_pos_b_x,
    input  logic [POS_W-1:0]        i_pos_b_y,
    input  logic [POS_W-1:0]        i_pos_b_z,
    input  logic [TAG_W-1:0]        i_pair_tag,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_force_x,
    output logic signed [OUT_W-1:0] o_force_y,
    output logic signed [OUT_W-1:0] o_force_z,
    output logic signed [OUT_W-1:0] o_pair_energy,
    output logic                    o_in_range,
    output logic                    o_saturated,
    output logic [TAG_W-1:0]        o_tag_out
);

    // positions along the sideband line where each unit's result appears
    localparam int P_DIV    = QUO_W - 1;
    localparam int P_M3     = P_DIV + 3 * MUL_LAT;
    localparam int P_X      = P_M3 + 1;
    localparam int P_M45    = P_X + MUL_LAT;
    localparam int P_M6     = P_M45 + MUL_LAT;
    localparam int SIDE_LEN = P_M6 + 1;

    localparam logic [CFG_W-1:0] BOX_RST    = 32'd125829120;
    localparam logic [CFG_W-1:0] SIGMA_RST  = 32'd16777216;
    localparam logic [CFG_W-1:0] WELL_RST   = 32'd16777216;
    localparam logic [CFG_W-1:0] CUTOFF_RST = 32'd21137968;
    localparam logic [CFG_W-1:0] SHIFT_RST  = 32'hFF000000;

    // configuration registers
    logic [2:0][CFG_W-1:0] r_box;
    logic [CFG_W-1:0]      r_sigma, r_well, r_cutoff;
    logic signed [CFG_W-1:0] r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box    <= {BOX_RST, BOX_RST, BOX_RST};
            r_sigma  <= SIGMA_RST;
            r_well   <= WELL_RST;
            r_cutoff <= CUTOFF_RST;
            r_shift  <= SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOX_X:        r_box[0] <= i_cfg_data;
                REG_BOX_Y:        r_box[1] <= i_cfg_data;
                REG_BOX_Z:        r_box[2] <= i_cfg_data;
                REG_SIGMA_SQ:     r_sigma  <= i_cfg_data;
                REG_WELL_DEPTH:   r_well   <= i_cfg_data;
                REG_CUTOFF_SQ:    r_cutoff <= i_cfg_data;
                REG_ENERGY_SHIFT: r_shift  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic en, out_ld;
    logic r_out_valid;
    logic [SIDE_LEN-1:0] r_vld;

    assign out_ld     = !r_out_valid || i_out_ready;
    assign en         = !r_vld[SIDE_LEN-1] || out_ld;
    assign o_in_ready = en;

    // distance front end
    logic  dist_valid;
    t_dist dist_res;

    ljpf_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_pos_a ({i_pos_a_z, i_pos_a_y, i_pos_a_x}),
        .i_pos_b ({i_pos_b_z, i_pos_b_y, i_pos_b_x}),
        .i_box   (r_box),
        .i_tag   (i_pair_tag),
        .o_valid (dist_valid),
        .o_dist  (dist_res)
    );

    // sideband line
    t_side [SIDE_LEN-1:0] r_side;
    t_side                n_side0;

    always_comb begin
        n_side0.dmag     = dist_res.dmag;
        n_side0.dneg     = dist_res.dneg;
        n_side0.tag      = dist_res.tag;
        n_side0.in_range = dist_res.r2 < {{(R2_W-CFG_W){1'b0}}, r_cutoff};
        n_side0.zero     = (dist_res.r2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[SIDE_LEN-2:0], dist_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side <= {r_side[SIDE_LEN-2:0], n_side0};
        end
    end

    // sigma^2 / r2 and eps / r2
    logic [1:0][QUO_W-1:0] quo;

    ljpf_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_den (dist_res.r2),
        .i_num ({r_well, r_sigma}),
        .o_quo (quo)
    );

    logic [MAG_W-1:0] s2, er;
    assign s2 = {{(MAG_W-QUO_W){1'b0}}, quo[0]};
    assign er = {{(MAG_W-QUO_W){1'b0}}, quo[1]};

    // powers of sigma^2 / r2
    logic [MAG_W-1:0] s4, s6, s12;
    logic [MUL_LAT-1:0][MAG_W-1:0] r_s2_d, r_s6_d;
    logic [P_M3-P_DIV-1:0][MAG_W-1:0] r_er_d;

    ljpf_mulq u_mul_s4 (.i_clk(i_clk), .i_en(en), .i_a(s2), .i_b(s2), .o_p(s4));
    ljpf_mulq u_mul_s6 (.i_clk(i_clk), .i_en(en), .i_a(s4), .i_b(r_s2_d[MUL_LAT-1]),
                        .o_p(s6));
    ljpf_mulq u_mul_s12 (.i_clk(i_clk), .i_en(en), .i_a(s6), .i_b(s6), .o_p(s12));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_d <= {r_s2_d[MUL_LAT-2:0], s2};
            r_s6_d <= {r_s6_d[MUL_LAT-2:0], s6};
            r_er_d <= {r_er_d[P_M3-P_DIV-2:0], er};
        end
    end

    // bracket terms and force scale
    logic [MAG_W-1:0] r_k48, r_dfmag, r_demag;
    logic             r_dfneg, r_deneg;
    logic [MAG_W-1:0] w_s6, w_erl;
    logic [MAG_W:0]   w_df, w_de, w_dfm, w_dem;

    always_comb begin
        w_s6  = r_s6_d[MUL_LAT-1];
        w_erl = r_er_d[P_M3-P_DIV-1];
        w_df  = {1'b0, s12} - {2'b00, w_s6[MAG_W-1:1]};
        w_de  = {1'b0, s12} - {1'b0, w_s6};
        w_dfm = w_df[MAG_W] ? -w_df : w_df;
        w_dem = w_de[MAG_W] ? -w_de : w_de;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k48 <= (w_erl << 5) + (w_erl << 4);
            if (s12 == BIG_MAG) begin
                r_dfmag <= BIG_MAG;
                r_dfneg <= 1'b0;
                r_demag <= BIG_MAG;
                r_deneg <= 1'b0;
            end else begin
                r_dfmag <= w_dfm[MAG_W-1:0];
                r_dfneg <= w_df[MAG_W];
                r_demag <= w_dem[MAG_W-1:0];
                r_deneg <= w_de[MAG_W];
            end
        end
    end

    // force over r and raw energy
    logic [MAG_W-1:0] fr_mag, e_mag;

    ljpf_mulq u_mul_fr (.i_clk(i_clk), .i_en(en), .i_a(r_k48), .i_b(r_dfmag), .o_p(fr_mag));
    ljpf_mulq u_mul_e (.i_clk(i_clk), .i_en(en),
                       .i_a({{(MAG_W-CFG_W-2){1'b0}}, r_well, 2'b00}),
                       .i_b(r_demag), .o_p(e_mag));

    logic [P_M6-P_X-1:0]   r_dfneg_d;
    logic [P_M45-P_X-1:0]  r_deneg_d;
    logic signed [P_M6-P_M45-1:0][63:0] r_e;
    logic signed [63:0] w_em, w_e;

    always_comb begin
        w_em = $signed({2'b00, e_mag});
        w_e  = (r_deneg_d[P_M45-P_X-1] ? -w_em : w_em)
             - $signed({{(64-CFG_W){r_shift[CFG_W-1]}}, r_shift});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dfneg_d <= {r_dfneg_d[P_M6-P_X-2:0], r_dfneg};
            r_deneg_d <= {r_deneg_d[P_M45-P_X-2:0], r_deneg};
            r_e       <= {r_e[P_M6-P_M45-2:0], w_e};
        end
    end

    // per-axis force magnitude
    logic [2:0][MAG_W-1:0] f_mag;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        ljpf_mulq u_mul_f (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (fr_mag),
            .i_b   ({{(MAG_W-POS_W){1'b0}}, r_side[P_M45].dmag[k]}),
            .o_p   (f_mag[k])
        );
    end

    // sign, clip and special cases
    t_side            w_sd;
    t_clip [2:0]      w_cf;
    t_clip            w_ce;
    logic [2:0][OUT_W-1:0] n_force;
    logic [OUT_W-1:0] n_energy;
    logic             n_sat;

    always_comb begin
        logic signed [63:0] fv;
        w_sd = r_side[SIDE_LEN-1];
        for (int k = 0; k < 3; k++) begin
            fv = $signed({2'b00, f_mag[k]});
            w_cf[k] = clip_out((r_dfneg_d[P_M6-P_X-1] ^ w_sd.dneg[k]) ? -fv : fv);
        end
        w_ce = clip_out(r_e[P_M6-P_M45-1]);
        if (!w_sd.in_range) begin
            n_force  = '0;
            n_energy = '0;
            n_sat    = 1'b0;
        end else if (w_sd.zero) begin
            n_force  = '0;
            n_energy = MAX_OUT[OUT_W-1:0];
            n_sat    = 1'b1;
        end else begin
            for (int k = 0; k < 3; k++) begin
                n_force[k] = w_cf[k].val;
            end
            n_energy = w_ce.val;
            n_sat    = w_cf[0].sat | w_cf[1].sat | w_cf[2].sat | w_ce.sat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= r_vld[SIDE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            o_force_x     <= n_force[0];
            o_force_y     <= n_force[1];
            o_force_z     <= n_force[2];
            o_pair_energy <= n_energy;
            o_in_range    <= w_sd.in_range;
            o_saturated   <= n_sat;
            o_tag_out     <= w_sd.tag;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== tb/lennard_jones_pair_force_unit_tb.sv =====
// Self-checking testbench for the Lennard-Jones pair force unit.
`timescale 1ns / 1ps

module lennard_jones_pair_force_unit_tb;
    import ljpf_pkg::*;

    localparam logic [63:0] MAG_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] HI48 = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] LO48 = -64'sh7FFF_FFFF_FFFF - 64'sd1;
    localparam int LATENCY = 78;
    localparam int N_RAND  = 1330;

    typedef struct packed {
        logic [OUT_W-1:0] fx;
        logic [OUT_W-1:0] fy;
        logic [OUT_W-1:0] fz;
        logic [OUT_W-1:0] energy;
        logic             in_range;
        logic             sat;
        logic [TAG_W-1:0] tag;
    } t_force_res;

    typedef struct {
        logic [POS_W-1:0] pa [3];
        logic [POS_W-1:0] pb [3];
        logic [TAG_W-1:0] tag;
        bit               has_fixed;
        t_force_res       fixed;
    } t_pair_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [POS_W-1:0] i_pos_a_x = '0, i_pos_a_y = '0, i_pos_a_z = '0;
    logic [POS_W-1:0] i_pos_b_x = '0, i_pos_b_y = '0, i_pos_b_z = '0;
    logic [TAG_W-1:0] i_pair_tag = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_force_x, o_force_y, o_force_z, o_pair_energy;
    logic o_in_range, o_saturated;
    logic [TAG_W-1:0] o_tag_out;

    // shadow registers
    logic [31:0] cfg_box [3];
    logic [31:0] cfg_sigma_sq, cfg_eps, cfg_cut_sq, cfg_shift;

    t_force_res expected_forces [$];
    int  n_errors = 0;
    int  n_sent = 0;
    int  rx_idle = 0;
    bit  quiet_phase = 1'b0;
    bit  long_hold = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    lennard_jones_pair_force_unit u_top (.*);

    // fixed-point product floor(a*b/2^F) with sticky overflow
    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        if (a == 0 || b == 0) return 64'd0;
        if (a >= MAG_MAX || b >= MAG_MAX) return MAG_MAX;
        p = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
        if (p >= {64'd0, MAG_MAX}) return MAG_MAX;
        return p[63:0];
    endfunction

    function automatic logic [63:0] qdiv(logic [31:0] num, logic [63:0] den);
        logic [63:0] q;
        q = ({32'd0, num} << FRAC_BITS) / den;
        return q >= MAG_MAX ? MAG_MAX : q;
    endfunction

    function automatic logic [OUT_W-1:0] clip48(logic signed [63:0] v, inout logic sat);
        if (v > HI48) begin sat = 1'b1; v = HI48; end
        if (v < LO48) begin sat = 1'b1; v = LO48; end
        return v[OUT_W-1:0];
    endfunction

    function automatic logic signed [63:0] mag_diff(logic [63:0] x, logic [63:0] y);
        if (x >= MAG_MAX) return $signed(MAG_MAX);
        return $signed(x) - $signed(y);
    endfunction

    // predict one pair result from the shadow registers
    function automatic t_force_res pair_force(t_pair_row r);
        t_force_res res;
        logic signed [63:0] d [3];
        logic signed [63:0] l, df, de, fr, e, sh;
        logic [63:0] r2, s2, s6, s12, er, k48, m, a, fm;
        logic [127:0] acc;
        logic sat;
        logic [OUT_W-1:0] f [3];
        acc = '0;
        sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            d[k] = $signed({32'd0, r.pa[k]}) - $signed({32'd0, r.pb[k]});
            l = $signed({32'd0, cfg_box[k]});
            if (2 * d[k] > l) d[k] -= l;
            if (2 * d[k] < -l) d[k] += l;
            a = d[k] < 0 ? -d[k] : d[k];
            acc += {64'd0, a} * {64'd0, a};
        end
        r2 = 64'(acc >> FRAC_BITS);
        res = '0;
        res.tag = r.tag;
        if (r2 >= {32'd0, cfg_cut_sq}) return res;
        res.in_range = 1'b1;
        if (r2 == 0) begin
            res.energy = HI48[OUT_W-1:0];
            res.sat = 1'b1;
            return res;
        end
        s2 = qdiv(cfg_sigma_sq, r2);
        s6 = qmul(qmul(s2, s2), s2);
        s12 = qmul(s6, s6);
        er = qdiv(cfg_eps, r2);
        k48 = (er > MAG_MAX / 48) ? MAG_MAX : er * 48;
        df = mag_diff(s12, s6 >> 1);
        m = qmul(k48, df < 0 ? -df : df);
        fr = df < 0 ? -$signed(m) : $signed(m);
        for (int k = 0; k < 3; k++) begin
            a = d[k] < 0 ? -d[k] : d[k];
            fm = qmul(fr < 0 ? -fr : fr, a);
            f[k] = clip48(((fr < 0) != (d[k] < 0)) ? -$signed(fm) : $signed(fm), sat);
        end
        de = mag_diff(s12, s6);
        m = qmul({32'd0, cfg_eps} * 4, de < 0 ? -de : de);
        sh = $signed({{32{cfg_shift[31]}}, cfg_shift});
        e = (de < 0 ? -$signed(m) : $signed(m)) - sh;
        res.energy = clip48(e, sat);
        res.fx = f[0];
        res.fy = f[1];
        res.fz = f[2];
        res.sat = sat;
        return res;
    endfunction

    // register write, only while idle
    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_BOX_X:        cfg_box[0] = val;
            REG_BOX_Y:        cfg_box[1] = val;
            REG_BOX_Z:        cfg_box[2] = val;
            REG_SIGMA_SQ:     cfg_sigma_sq = val;
            REG_WELL_DEPTH:   cfg_eps = val;
            REG_CUTOFF_SQ:    cfg_cut_sq = val;
            REG_ENERGY_SHIFT: cfg_shift = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (expected_forces.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // offer one pair and hold it until the transfer
    task automatic send_pair(t_pair_row r);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pos_a_x <= r.pa[0]; i_pos_a_y <= r.pa[1]; i_pos_a_z <= r.pa[2];
        i_pos_b_x <= r.pb[0]; i_pos_b_y <= r.pb[1]; i_pos_b_z <= r.pb[2];
        i_pair_tag <= r.tag;
        do @(posedge i_clk); while (!o_in_ready);
        expected_forces.push_back(r.has_fixed ? r.fixed : pair_force(r));
        n_sent++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // random pair: mostly close pairs that land inside the cutoff
    function automatic t_pair_row rand_pair();
        t_pair_row r;
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            r.pa[k] = (mode == 0) ? rand_word() : $urandom_range(0, 32'h07FF_FFFF);
            if (mode == 0) r.pb[k] = rand_word();
            else if (mode < 8) r.pb[k] = r.pa[k] + $urandom_range(0, 32'h0180_0000)
                                          - 32'h00C0_0000;
            else r.pb[k] = r.pa[k] + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        end
        r.tag = 16'($urandom);
        r.has_fixed = 1'b0;
        r.fixed = '0;
        return r;
    endfunction

    // receiver side with random idle bursts and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (long_hold) begin
            i_out_ready <= 1'b0;
        end else if (quiet_phase) begin
            i_out_ready <= 1'b1;
        end else if (rx_idle > 0) begin
            i_out_ready <= 1'b0;
            rx_idle--;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            rx_idle = $urandom_range(0, 11);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_force_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_forces.size() == 0) begin
                $display("%0t: unexpected result tag %h", $realtime, o_tag_out);
                n_errors++;
            end else begin
                want = expected_forces.pop_front();
                if (want.fx !== o_force_x || want.fy !== o_force_y
                        || want.fz !== o_force_z) begin
                    $display("%0t: force exp %h %h %h got %h %h %h", $realtime,
                             want.fx, want.fy, want.fz, o_force_x, o_force_y, o_force_z);
                    n_errors++;
                end
                if (want.energy !== o_pair_energy) begin
                    $display("%0t: energy exp %h got %h", $realtime,
                             want.energy, o_pair_energy);
                    n_errors++;
                end
                if (want.in_range !== o_in_range || want.sat !== o_saturated
                        || want.tag !== o_tag_out) begin
                    $display("%0t: flags/tag exp %b %b %h got %b %b %h", $realtime,
                             want.in_range, want.sat, want.tag,
                             o_in_range, o_saturated, o_tag_out);
                    n_errors++;
                end
            end
        end
    end

    // long receiver hold-off so the pipe fills
    initial begin
        int hold_cycles;
        hold_cycles = 0;
        wait (n_sent == 100);
        long_hold = 1'b1;
        while (hold_cycles < 250) begin
            @(posedge i_clk);
            hold_cycles++;
        end
        long_hold = 1'b0;
    end

    initial begin
        #4000000;
        $display("lennard_jones_pair_force_unit_tb: errors");
        $finish;
    end

    initial begin
        t_pair_row dir_rows [$];
        t_pair_row r;
        logic [31:0] sets [4][7];
        cfg_box = '{32'd125829120, 32'd125829120, 32'd125829120};
        cfg_sigma_sq = 32'd16777216;
        cfg_eps = 32'd16777216;
        cfg_cut_sq = 32'd21137968;
        cfg_shift = 32'hFF00_0000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: zero distance, beyond cutoff, box wrap, near range
        r.has_fixed = 1'b1;
        r.pa = '{32'h0100_0000, 32'h0200_0000, 32'h0300_0000}; r.pb = r.pa;
        r.tag = 16'hFFFF;
        r.fixed = '{fx: '0, fy: '0, fz: '0, energy: HI48[OUT_W-1:0],
                    in_range: 1'b1, sat: 1'b1, tag: 16'hFFFF};
        dir_rows.push_back(r);
        r.pa = '{32'h0, 32'h0, 32'h0}; r.pb = '{32'h0300_0000, 32'h0, 32'h0};
        r.tag = 16'h0000;
        r.fixed = '{fx: '0, fy: '0, fz: '0, energy: '0, in_range: 1'b0,
                    sat: 1'b0, tag: 16'h0000};
        dir_rows.push_back(r);
        r.pa = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        r.pb = '{32'h0, 32'h0, 32'h0};
        r.tag = 16'h5A5A;
        r.fixed.tag = 16'h5A5A;
        dir_rows.push_back(r);
        r.has_fixed = 1'b0;
        for (int k = 0; k < 12; k++) begin
            r.pa = '{32'h0000_0000, 32'h0400_0000, 32'h0700_0000};
            r.pb = '{32'h0000_0000 + k * 32'h0010_0000, 32'h0400_0000,
                     32'h0780_0000 - k * 32'h0008_0000};
            r.tag = 16'(k);
            dir_rows.push_back(r);
        end
        r.pa = '{32'h0000_0100, 32'h0, 32'h0}; r.pb = '{32'h0, 32'h0, 32'h0};
        r.tag = 16'h1234;
        dir_rows.push_back(r);
        foreach (dir_rows[i]) send_pair(dir_rows[i]);
        i_in_valid <= 1'b0;
        drain();

        // settings: reset-like, extremes, all-zero box and sigma, small box with small sigma
        sets[0] = '{32'h0780_0000, 32'h0400_0000, 32'h0A00_0000, 32'h0100_0000,
                    32'h0100_0000, 32'h0400_0000, 32'h0000_0000};
        sets[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
        sets[2] = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0200_0000, 32'h8000_0000};
        sets[3] = '{32'h0100_0000, 32'h0180_0000, 32'h0200_0000, 32'h0040_0000,
                    32'h0280_0000, 32'h0300_0000, 32'hFFF0_0000};
        for (int s = 0; s < 4; s++) begin
            for (int i = 0; i < 7; i++) write_reg(t_cfg_idx'(i), sets[s][i]);
            if (s == 3) quiet_phase = 1'b1;
            for (int n = 0; n < N_RAND / 4; n++) send_pair(rand_pair());
            i_in_valid <= 1'b0;
            drain();
        end

        if (n_errors == 0) begin
            $display("lennard_jones_pair_force_unit_tb: clean");
        end else begin
            $display("lennard_jones_pair_force_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ljpf_pkg.sv
rtl/core/ljpf_dist.sv
rtl/core/ljpf_div.sv
rtl/core/ljpf_mulq.sv
rtl/core/lennard_jones_pair_force_unit.sv
tb/lennard_jones_pair_force_unit_tb.sv
